// File: src/cld_pkg.sv
`default_nettype none

package cld_pkg;

  // Ring geometry: positions count modulo twice the depth so full and empty differ
  localparam int unsigned BUF_DEPTH = 128;
  localparam int unsigned POS_MOD   = 2 * BUF_DEPTH;
  localparam int unsigned POS_W     = $clog2(POS_MOD);
  localparam int unsigned SLOT_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // Key codes
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_NUL    = 8'h00;

  // Item commands
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Read status codes
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_BYTE = 2'd1;
  localparam logic [1:0] RD_EOF  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic       command;
    logic [7:0] key_char;
    logic       first_of_read;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       dump_request;
    logic       line_ready;
    logic [1:0] read_status;
    logic [7:0] read_char;
    logic       end_of_line;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: src/cld_in_if.sv
`default_nettype none

interface cld_in_if;
  import cld_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/cld_out_if.sv
`default_nettype none

interface cld_out_if;
  import cld_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/console_line_discipline_top.sv
// An accepted item is registered together with its ring-memory read; the item then
// waits in execution until the output register is free, and that update step writes
// the ring, moves the positions and loads the result. No new item is taken before it.
// A new item is taken while the previous result still waits at the output.
// Reset (async, active low) clears the read, commit and edit positions and the
// output valid; the line store holds no defined contents until written.
`default_nettype none

module console_line_discipline_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cld_in_if.sink    in_i,
  cld_out_if.source out_o
);
  import cld_pkg::*;

  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;

  cld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  cld_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_i.data),
    .result_o (out_o.data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

// File: src/cld_ctrl.sv
`default_nettype none

module cld_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_ready_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output cld_pkg::dp_cmd_t       cmd_o
);
  import cld_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        // hold the item until the output register can take its result
        cmd_o.commit = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_EXEC) && !in_ready_o)
    else $error("accepted item did not enter execution");
  a_commit_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && out_valid_q) |-> out_ready_i)
    else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// File: src/cld_dp.sv
`default_nettype none

module cld_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cld_pkg::dp_cmd_t   cmd_i,
  input  wire cld_pkg::in_item_t  item_i,
  output cld_pkg::out_item_t      result_o
);
  import cld_pkg::*;

  function automatic logic [POS_W-1:0] pos_inc(logic [POS_W-1:0] p);
    return (p == POS_W'(POS_MOD - 1)) ? '0 : p + POS_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] pos_dec(logic [POS_W-1:0] p);
    return (p == '0) ? POS_W'(POS_MOD - 1) : p - POS_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] pos_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[POS_W]) d = d + (POS_W+1)'(POS_MOD);
    return d[POS_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(logic [POS_W-1:0] p);
    logic [POS_W-1:0] s;
    s = (p >= POS_W'(BUF_DEPTH)) ? p - POS_W'(BUF_DEPTH) : p;
    return SLOT_W'(s);
  endfunction

  logic [7:0]       mem_q [BUF_DEPTH];
  logic [7:0]       rdata_q;
  in_item_t         item_q;
  out_item_t        result_q, result_d;
  logic [POS_W-1:0] read_pos_q, read_pos_d;
  logic [POS_W-1:0] commit_pos_q, commit_pos_d;
  logic [POS_W-1:0] edit_pos_q, edit_pos_d;
  logic             wr_en;
  logic [7:0]       wr_char;
  logic [POS_W-1:0] fill, edit_next, kill_len;
  logic [31:0]      kill_wide;

  assign fill      = pos_diff(edit_pos_q, read_pos_q);
  assign edit_next = pos_inc(edit_pos_q);
  assign kill_len  = pos_diff(edit_pos_q, commit_pos_q);
  assign kill_wide = 32'(kill_len);
  assign wr_char   = (item_q.key_char == KEY_CR) ? KEY_LF : item_q.key_char;

  always_comb begin
    result_d     = '0;
    read_pos_d   = read_pos_q;
    commit_pos_d = commit_pos_q;
    edit_pos_d   = edit_pos_q;
    wr_en        = 1'b0;
    if (item_q.command == CMD_KEY) begin
      if (item_q.key_char == KEY_CTRL_P) begin
        result_d.dump_request = 1'b1;
      end else if (item_q.key_char == KEY_CTRL_U) begin
        result_d.erase_count = kill_wide[7:0];
        edit_pos_d           = commit_pos_q;
      end else if (item_q.key_char == KEY_CTRL_H || item_q.key_char == KEY_DEL) begin
        if (edit_pos_q != commit_pos_q) begin
          edit_pos_d           = pos_dec(edit_pos_q);
          result_d.erase_count = 8'd1;
        end
      end else if (item_q.key_char != KEY_NUL && fill < POS_W'(BUF_DEPTH)) begin
        result_d.echo_valid = 1'b1;
        result_d.echo_char  = wr_char;
        wr_en               = 1'b1;
        edit_pos_d          = edit_next;
        // commit on line end, end of file, or the byte that fills the ring
        if (wr_char == KEY_LF || wr_char == KEY_CTRL_D ||
            pos_diff(edit_next, read_pos_q) == POS_W'(BUF_DEPTH)) begin
          commit_pos_d        = edit_next;
          result_d.line_ready = 1'b1;
        end
      end
    end else if (read_pos_q != commit_pos_q) begin
      if (rdata_q == KEY_CTRL_D) begin
        result_d.read_status = RD_EOF;
        // leave the Ctrl-D in place unless it opens the read
        if (item_q.first_of_read) read_pos_d = pos_inc(read_pos_q);
      end else begin
        result_d.read_status = RD_BYTE;
        result_d.read_char   = rdata_q;
        result_d.end_of_line = (rdata_q == KEY_LF);
        read_pos_d           = pos_inc(read_pos_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q  <= item_i;
      rdata_q <= mem_q[slot_of(read_pos_q)];
    end
    if (cmd_i.commit && wr_en) mem_q[slot_of(edit_pos_q)] <= wr_char;
    if (cmd_i.commit) result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos_q   <= '0;
      commit_pos_q <= '0;
      edit_pos_q   <= '0;
    end else if (cmd_i.commit) begin
      read_pos_q   <= read_pos_d;
      commit_pos_q <= commit_pos_d;
      edit_pos_q   <= edit_pos_d;
    end
  end

  assign result_o = result_q;

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= POS_W'(BUF_DEPTH))
    else $error("edit position ran past the ring");
  a_commit_within_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_diff(commit_pos_q, read_pos_q) <= fill)
    else $error("commit position beyond edit position");
  a_store_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && wr_en) |-> fill < POS_W'(BUF_DEPTH))
    else $error("byte stored into a full ring");
`endif

endmodule

`default_nettype wire
